### design/triangle_node_map_to_sphere_assert.svh
// ----------------------------------------------------------------------------
// Triangle node sphere map assertion macros
// Clocked assertion wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_NODE_MAP_TO_SPHERE_ASSERT_SVH
`define TRIANGLE_NODE_MAP_TO_SPHERE_ASSERT_SVH

// checked only outside reset
`define TNMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge
`define TNMS_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/tnms_pkg.sv
// ----------------------------------------------------------------------------
// Triangle node sphere map package
// Beat types, control struct, width and latency helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tnms_pkg;

  localparam int COORD_BITS = 16;
  localparam int V_BITS     = 31;
  localparam int S_BITS     = 62;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] vertex_a_x;
    logic signed [COORD_BITS-1:0] vertex_a_y;
    logic signed [COORD_BITS-1:0] vertex_a_z;
    logic signed [COORD_BITS-1:0] vertex_b_x;
    logic signed [COORD_BITS-1:0] vertex_b_y;
    logic signed [COORD_BITS-1:0] vertex_b_z;
    logic signed [COORD_BITS-1:0] vertex_c_x;
    logic signed [COORD_BITS-1:0] vertex_c_y;
    logic signed [COORD_BITS-1:0] vertex_c_z;
    logic signed [COORD_BITS-1:0] ref_r;
    logic signed [COORD_BITS-1:0] ref_s;
  } tnms_node_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [COORD_BITS-1:0] out_z;
    logic                         degenerate;
  } tnms_result_t;

  typedef struct packed {
    logic valid;
    logic degenerate;
    logic found;
  } tnms_ctl_t;

  typedef struct packed {
    logic [2:0]             neg;
    logic [2:0][V_BITS-1:0] mag;
  } tnms_mag_t;

  function automatic int tnms_weight_bits(int frac);
    return ((COORD_BITS > frac + 1) ? COORD_BITS : frac + 1) + 2;
  endfunction

  function automatic int tnms_l_bits(int frac);
    int lw;
    lw = COORD_BITS + tnms_weight_bits(frac) + 2;
    return (lw > V_BITS + 1) ? lw : V_BITS + 1;
  endfunction

  function automatic int tnms_latency(int frac);
    return 3 + (tnms_l_bits(frac) - V_BITS + 1) + 2 + V_BITS + 1 + (frac + 1) + 1;
  endfunction

endpackage

### design/tnms_shift_cell.sv
// ----------------------------------------------------------------------------
// Normalizing shift cell
// Tests one shift amount; the first cell whose shift fits all axes wins.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tnms_shift_cell #(
  parameter int L_W   = 36,
  parameter int SHIFT = 0
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tnms_pkg::tnms_ctl_t                  prev_ctl,
  input  logic [2:0][L_W-1:0]                  prev_l,
  input  logic [2:0][tnms_pkg::V_BITS:0]       prev_v,
  output tnms_pkg::tnms_ctl_t                  ctl,
  output logic [2:0][L_W-1:0]                  l,
  output logic [2:0][tnms_pkg::V_BITS:0]       v
);
  import tnms_pkg::*;

  localparam logic signed [L_W-1:0] LIM_HI = L_W'(64'sd1 <<< (V_BITS - 1));
  localparam logic signed [L_W-1:0] LIM_LO = -LIM_HI;

  logic signed [L_W-1:0] sh [3];
  logic [2:0]            in_range;
  logic                  take;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh[i]       = $signed(prev_l[i]) >>> SHIFT;
      in_range[i] = (sh[i] >= LIM_LO) && (sh[i] <= LIM_HI);
    end
  end

  assign take = !prev_ctl.found && (&in_range);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl.valid      <= prev_ctl.valid;
      ctl.degenerate <= prev_ctl.degenerate;
      ctl.found      <= prev_ctl.found | (&in_range);
    end
    l <= prev_l;
    for (int i = 0; i < 3; i++) begin
      v[i] <= take ? sh[i][V_BITS:0] : prev_v[i];
    end
  end

endmodule

### design/tnms_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// One result bit of the digit-by-digit integer square root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tnms_sqrt_cell #(
  parameter int J = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tnms_pkg::tnms_ctl_t           prev_ctl,
  input  tnms_pkg::tnms_mag_t           prev_mag,
  input  logic [tnms_pkg::S_BITS-1:0]   prev_rem,
  input  logic [tnms_pkg::S_BITS-1:0]   prev_root,
  output tnms_pkg::tnms_ctl_t           ctl,
  output tnms_pkg::tnms_mag_t           mag,
  output logic [tnms_pkg::S_BITS-1:0]   rem,
  output logic [tnms_pkg::S_BITS-1:0]   root
);
  import tnms_pkg::*;

  localparam logic [S_BITS-1:0] BIT = S_BITS'(1) << (2 * J);

  logic [S_BITS-1:0] trial;
  logic              fits;

  assign trial = prev_root + BIT;
  assign fits  = prev_rem >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= prev_ctl;
    end
    mag  <= prev_mag;
    rem  <= fits ? prev_rem - trial : prev_rem;
    root <= fits ? (prev_root >> 1) + BIT : prev_root >> 1;
  end

endmodule

### design/tnms_div_cell.sv
// ----------------------------------------------------------------------------
// Restoring divider cell
// One quotient bit for all three axes against a shared divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tnms_div_cell #(
  parameter int D_W = 48,
  parameter int Q_W = 15,
  parameter int J   = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tnms_pkg::tnms_ctl_t    prev_ctl,
  input  logic [2:0]             prev_neg,
  input  logic [D_W-1:0]         prev_den,
  input  logic [2:0][D_W-1:0]    prev_rem,
  input  logic [2:0][Q_W-1:0]    prev_quo,
  output tnms_pkg::tnms_ctl_t    ctl,
  output logic [2:0]             neg,
  output logic [D_W-1:0]         den,
  output logic [2:0][D_W-1:0]    rem,
  output logic [2:0][Q_W-1:0]    quo
);
  import tnms_pkg::*;

  logic [D_W-1:0]          d_sh;
  logic [2:0]              fits;
  logic [2:0][D_W-1:0]     rem_next;
  logic [2:0][Q_W-1:0]     quo_next;

  assign d_sh = prev_den << J;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fits[i]        = prev_rem[i] >= d_sh;
      rem_next[i]    = fits[i] ? prev_rem[i] - d_sh : prev_rem[i];
      quo_next[i]    = prev_quo[i];
      quo_next[i][J] = fits[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= prev_ctl;
    end
    neg <= prev_neg;
    den <= prev_den;
    rem <= rem_next;
    quo <= quo_next;
  end

endmodule

### design/triangle_node_map_to_sphere.sv
// ----------------------------------------------------------------------------
// Triangle node map to unit sphere
// Affine map of a reference node onto a triangle, scaled to unit length.
// ----------------------------------------------------------------------------
// Throughput: one node per clock; busy stays low.
// Pipeline: an accepted node reaches done through the shift cells, 31 square
//   root cells, FRAC_BITS+1 divider cells and 7 fixed stages.
// Reset: clears every stage valid bit; nodes in flight are dropped.
`timescale 1ns / 1ps

module triangle_node_map_to_sphere #(
  parameter int FRAC_BITS = 14
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  tnms_pkg::tnms_node_t   node,
  output logic                   done,
  output tnms_pkg::tnms_result_t result
);
  import tnms_pkg::*;

  localparam int W_W     = tnms_weight_bits(FRAC_BITS);
  localparam int P_W     = COORD_BITS + W_W;
  localparam int L_W     = tnms_l_bits(FRAC_BITS);
  localparam int N_SHIFT = L_W - V_BITS + 1;
  localparam int Q_W     = FRAC_BITS + 1;
  localparam int D_W     = V_BITS + FRAC_BITS + 3;
  localparam int N_W     = V_BITS + 1;
  localparam int E_W     = ((Q_W + 1 > COORD_BITS) ? Q_W + 1 : COORD_BITS) + 1;

  localparam logic signed [W_W-1:0] ONE_W   = W_W'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [E_W-1:0] SAT_MAX = E_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [E_W-1:0] SAT_MIN = -SAT_MAX - E_W'(1);

  // weights and affine sums
  logic                          v1, v2, v3;
  logic signed [COORD_BITS-1:0]  vtx1 [9];
  logic signed [W_W-1:0]         w1 [3];
  logic signed [P_W-1:0]         prod2 [9];
  logic [2:0][L_W-1:0]           l3;
  logic signed [W_W-1:0]         r_ext, s_ext;

  assign busy  = 1'b0;
  assign r_ext = W_W'(node.ref_r);
  assign s_ext = W_W'(node.ref_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start & ~busy;
      v2 <= v1;
      v3 <= v2;
    end
    vtx1[0] <= node.vertex_a_x;
    vtx1[1] <= node.vertex_a_y;
    vtx1[2] <= node.vertex_a_z;
    vtx1[3] <= node.vertex_b_x;
    vtx1[4] <= node.vertex_b_y;
    vtx1[5] <= node.vertex_b_z;
    vtx1[6] <= node.vertex_c_x;
    vtx1[7] <= node.vertex_c_y;
    vtx1[8] <= node.vertex_c_z;
    w1[0]   <= -(r_ext + s_ext);
    w1[1]   <= ONE_W + r_ext;
    w1[2]   <= ONE_W + s_ext;
    for (int g = 0; g < 3; g++) begin
      for (int i = 0; i < 3; i++) begin
        prod2[3*g+i] <= P_W'(w1[g]) * P_W'(vtx1[3*g+i]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      l3[i] <= L_W'(prod2[i]) + L_W'(prod2[3+i]) + L_W'(prod2[6+i]);
    end
  end

  // normalizing shift chain
  tnms_ctl_t              sctl [N_SHIFT+1];
  logic [2:0][L_W-1:0]    sl   [N_SHIFT+1];
  logic [2:0][V_BITS:0]   sv   [N_SHIFT+1];

  assign sctl[0] = '{valid: v3, degenerate: (l3 == '0), found: 1'b0};
  assign sl[0]   = l3;
  assign sv[0]   = '0;

  for (genvar k = 0; k < N_SHIFT; k++) begin : g_shift
    tnms_shift_cell #(.L_W(L_W), .SHIFT(k)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .prev_ctl (sctl[k]),
      .prev_l   (sl[k]),
      .prev_v   (sv[k]),
      .ctl      (sctl[k+1]),
      .l        (sl[k+1]),
      .v        (sv[k+1])
    );
  end

  // squares and sum
  tnms_ctl_t         qctl, uctl;
  tnms_mag_t         mag_c, qmag, umag;
  logic [S_BITS-1:0] sq [3];
  logic [S_BITS-1:0] usum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c.neg[i] = sv[N_SHIFT][i][V_BITS];
      mag_c.mag[i] = mag_c.neg[i] ? V_BITS'(-sv[N_SHIFT][i]) : V_BITS'(sv[N_SHIFT][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qctl <= '0;
      uctl <= '0;
    end else begin
      qctl <= sctl[N_SHIFT];
      uctl <= qctl;
    end
    qmag <= mag_c;
    for (int i = 0; i < 3; i++) begin
      sq[i] <= S_BITS'(mag_c.mag[i]) * S_BITS'(mag_c.mag[i]);
    end
    umag <= qmag;
    usum <= sq[0] + sq[1] + sq[2];
  end

  // square root chain
  tnms_ctl_t         rctl  [V_BITS+1];
  tnms_mag_t         rmag  [V_BITS+1];
  logic [S_BITS-1:0] rrem  [V_BITS+1];
  logic [S_BITS-1:0] rroot [V_BITS+1];

  assign rctl[0]  = uctl;
  assign rmag[0]  = umag;
  assign rrem[0]  = usum;
  assign rroot[0] = '0;

  for (genvar j = 0; j < V_BITS; j++) begin : g_sqrt
    tnms_sqrt_cell #(.J(V_BITS - 1 - j)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .prev_ctl  (rctl[j]),
      .prev_mag  (rmag[j]),
      .prev_rem  (rrem[j]),
      .prev_root (rroot[j]),
      .ctl       (rctl[j+1]),
      .mag       (rmag[j+1]),
      .rem       (rrem[j+1]),
      .root      (rroot[j+1])
    );
  end

  // divider operands
  logic [N_W-1:0]       norm_c;
  tnms_ctl_t            pctl;
  logic [2:0]           pneg;
  logic [D_W-1:0]       pden;
  logic [2:0][D_W-1:0]  prem;

  assign norm_c = (rroot[V_BITS][N_W-1:0] == '0) ? N_W'(1) : rroot[V_BITS][N_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pctl <= '0;
    end else begin
      pctl <= rctl[V_BITS];
    end
    pneg <= rmag[V_BITS].neg;
    pden <= D_W'(norm_c) << 1;
    for (int i = 0; i < 3; i++) begin
      prem[i] <= (D_W'(rmag[V_BITS].mag[i]) << Q_W) + D_W'(norm_c);
    end
  end

  // divider chain
  tnms_ctl_t           dctl [Q_W+1];
  logic [2:0]          dneg [Q_W+1];
  logic [D_W-1:0]      dden [Q_W+1];
  logic [2:0][D_W-1:0] drem [Q_W+1];
  logic [2:0][Q_W-1:0] dquo [Q_W+1];

  assign dctl[0] = pctl;
  assign dneg[0] = pneg;
  assign dden[0] = pden;
  assign drem[0] = prem;
  assign dquo[0] = '0;

  for (genvar j = 0; j < Q_W; j++) begin : g_div
    tnms_div_cell #(.D_W(D_W), .Q_W(Q_W), .J(Q_W - 1 - j)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .prev_ctl (dctl[j]),
      .prev_neg (dneg[j]),
      .prev_den (dden[j]),
      .prev_rem (drem[j]),
      .prev_quo (dquo[j]),
      .ctl      (dctl[j+1]),
      .neg      (dneg[j+1]),
      .den      (dden[j+1]),
      .rem      (drem[j+1]),
      .quo      (dquo[j+1])
    );
  end

  // sign and saturate
  logic signed [E_W-1:0]        sval [3];
  logic signed [COORD_BITS-1:0] oval [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sval[i] = E_W'(dquo[Q_W][i]);
      if (dneg[Q_W][i]) begin
        sval[i] = -sval[i];
      end
      if (sval[i] > SAT_MAX) begin
        oval[i] = SAT_MAX[COORD_BITS-1:0];
      end else if (sval[i] < SAT_MIN) begin
        oval[i] = SAT_MIN[COORD_BITS-1:0];
      end else begin
        oval[i] = sval[i][COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dctl[Q_W].valid;
    end
    result.out_x      <= oval[0];
    result.out_y      <= oval[1];
    result.out_z      <= oval[2];
    result.degenerate <= dctl[Q_W].degenerate;
  end

endmodule

### design/tnms_checker.sv
// ----------------------------------------------------------------------------
// Triangle node sphere map port checker
// Latency and degenerate-point checks on the top level ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "triangle_node_map_to_sphere_assert.svh"

module tnms_checker #(
  parameter int FRAC_BITS = 14
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input tnms_pkg::tnms_node_t   node,
  input logic                   done,
  input tnms_pkg::tnms_result_t result
);
  import tnms_pkg::*;

  localparam int LAT = tnms_latency(FRAC_BITS);

  logic accept;
  logic zero_node;

  assign accept    = start && !busy;
  assign zero_node = (node.vertex_a_x == '0) && (node.vertex_a_y == '0) &&
                     (node.vertex_a_z == '0) && (node.vertex_b_x == '0) &&
                     (node.vertex_b_y == '0) && (node.vertex_b_z == '0) &&
                     (node.vertex_c_x == '0) && (node.vertex_c_y == '0) &&
                     (node.vertex_c_z == '0);

  `TNMS_ASSERT(a_beat_out, accept |-> ##LAT done, "accepted node produced no result")
  `TNMS_ASSERT(a_beat_src, done |-> $past(accept, LAT), "result without matching node")
  `TNMS_ASSERT(a_zero_node, accept && zero_node |-> ##LAT result.degenerate, "zero node not flagged")
  `TNMS_ASSERT_CLK(a_deg_zero, done && result.degenerate |-> result.out_x == '0 && result.out_y == '0 && result.out_z == '0, "degenerate result not zero")

endmodule

bind triangle_node_map_to_sphere tnms_checker #(.FRAC_BITS(FRAC_BITS)) u_tnms_checker (.*);
